### src/bmprle_pkg.sv
// ----------------------------------------------------------------------------
// BMP RLE decoder package
// Shared widths, codes and the command record passed from the parser to the
// result stage.
// ----------------------------------------------------------------------------
package bmprle_pkg;

	// Fixed field widths of the ports.
	localparam int DATA_W     = 8;
	localparam int CFG_W      = 14;
	localparam int CFG_IDX_W  = 2;
	localparam int LEN_W      = 8;
	localparam int ROW_OUT_W  = 13;
	localparam int KIND_W     = 2;
	localparam int M_TDATA_W  = 56;

	// Largest image dimension, default and upper bound of its range.
	localparam int MAX_DIMENSION_DEF = 8192;
	localparam int DIM_LIMIT         = 16384;

	// Width of a position that may run up to one byte past the largest size.
	localparam int POS_W = $clog2(DIM_LIMIT + 256);

	// Entries of the queue between parser and result stage.
	localparam int QUEUE_DEPTH = 4;

	// Parse phases of the compressed stream.
	typedef enum logic [2:0] {
		PH_COUNT,
		PH_VALUE,
		PH_DX,
		PH_DY,
		PH_ABS,
		PH_PAD
	} phase_t;

	// Result kinds.
	typedef enum logic [KIND_W-1:0] {
		KIND_RUN   = 2'd0,
		KIND_DONE  = 2'd1,
		KIND_TRUNC = 2'd2
	} kind_t;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH   = 2'd0,
		REG_IMAGE_HEIGHT  = 2'd1,
		REG_NIBBLE_MODE   = 2'd2,
		REG_ROWS_TOP_DOWN = 2'd3
	} reg_idx_t;

	// One parsed byte: an unclipped run write and/or a stream status.
	typedef struct packed {
		logic              run_v;
		logic [POS_W-1:0]  row;
		logic [POS_W-1:0]  col;
		logic [LEN_W-1:0]  len;
		logic [DATA_W-1:0] even_idx;
		logic [DATA_W-1:0] odd_idx;
		logic              stat_v;
		kind_t             stat_kind;
	} cmd_t;

endpackage

### src/bmprle_front.sv
// ----------------------------------------------------------------------------
// BMP RLE parser
// Takes one compressed byte per cycle while in_accept is high, tracks the
// parse phase and cursor, and emits one command per byte with a run write or status.
// ----------------------------------------------------------------------------
module bmprle_front #(
	parameter int MAX_DIMENSION = bmprle_pkg::MAX_DIMENSION_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [$clog2(MAX_DIMENSION + 1)-1:0]  eff_w,
	input  logic [$clog2(MAX_DIMENSION + 1)-1:0]  eff_h,
	input  logic                                  nibble_mode,
	input  logic                                  in_accept,
	input  logic [bmprle_pkg::DATA_W-1:0]         in_byte,
	input  logic                                  in_final,
	output logic                                  push,
	output bmprle_pkg::cmd_t                      cmd
);

	localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
	localparam int SUM_W = $clog2(MAX_DIMENSION + 256);

	bmprle_pkg::phase_t                  phase_q, phase_n;
	logic [bmprle_pkg::LEN_W-1:0]        held_q, held_n;
	logic [DIM_W-1:0]                    column_q, column_n;
	logic [SUM_W-1:0]                    file_row_q, file_row_n;
	logic [bmprle_pkg::LEN_W-1:0]        abs_left_q, abs_left_n;
	logic                                pad_q, pad_n;
	logic                                finished_q, finished_n;

	logic [SUM_W-1:0]                    col_sum;
	logic [DIM_W-1:0]                    col_clamped;
	logic [SUM_W-1:0]                    row_inc;
	logic [SUM_W-1:0]                    row_add;
	logic [bmprle_pkg::LEN_W-1:0]        abs_off;
	logic [bmprle_pkg::LEN_W-1:0]        abs_step;
	logic [bmprle_pkg::DATA_W:0]         byte_plus1;
	logic [bmprle_pkg::DATA_W-1:0]       nib_hi;
	logic [bmprle_pkg::DATA_W-1:0]       nib_lo;
	logic                                run_v;
	logic [SUM_W-1:0]                    run_col;
	logic [bmprle_pkg::LEN_W-1:0]        run_len;
	logic [bmprle_pkg::DATA_W-1:0]       run_even;
	logic [bmprle_pkg::DATA_W-1:0]       run_odd;
	logic                                run_open;

	// Cursor arithmetic shared by several phases.
	assign col_sum     = SUM_W'(column_q) + SUM_W'(held_q);
	assign col_clamped = (col_sum > SUM_W'(eff_w)) ? eff_w : col_sum[DIM_W-1:0];
	assign row_inc     = file_row_q + SUM_W'(1);
	assign row_add     = file_row_q + SUM_W'(in_byte);
	assign abs_off     = held_q - abs_left_q;
	assign abs_step    = (nibble_mode && (abs_left_q >= 8'd2)) ? 8'd2 : 8'd1;
	assign byte_plus1  = {1'b0, in_byte} + 9'd1;
	assign nib_hi      = {4'b0000, in_byte[7:4]};
	assign nib_lo      = {4'b0000, in_byte[3:0]};

	// Next parse state and the run write caused by this byte.
	always_comb begin
		phase_n    = phase_q;
		held_n     = held_q;
		column_n   = column_q;
		file_row_n = file_row_q;
		abs_left_n = abs_left_q;
		pad_n      = pad_q;
		finished_n = finished_q;
		run_v      = 1'b0;
		run_col    = SUM_W'(column_q);
		run_len    = held_q;
		run_even   = in_byte;
		run_odd    = in_byte;

		if (!finished_q) begin
			unique case (phase_q)
				bmprle_pkg::PH_VALUE: begin
					if (held_q != '0) begin
						// Encoded run of held_q pixels.
						run_v = 1'b1;
						if (nibble_mode) begin
							run_even = nib_hi;
							run_odd  = nib_lo;
						end
						column_n = col_clamped;
						phase_n  = bmprle_pkg::PH_COUNT;
					end else if (in_byte == 8'd0) begin
						// End of line.
						column_n   = '0;
						file_row_n = row_inc;
						if (row_inc >= SUM_W'(eff_h)) begin
							finished_n = 1'b1;
						end
						phase_n = bmprle_pkg::PH_COUNT;
					end else if (in_byte == 8'd1) begin
						// End of bitmap.
						finished_n = 1'b1;
						phase_n    = bmprle_pkg::PH_COUNT;
					end else if (in_byte == 8'd2) begin
						phase_n = bmprle_pkg::PH_DX;
					end else begin
						// Start of an absolute run; the pad rule is fixed here.
						held_n     = in_byte;
						abs_left_n = in_byte;
						pad_n      = nibble_mode ? byte_plus1[1] : in_byte[0];
						phase_n    = bmprle_pkg::PH_ABS;
					end
				end
				bmprle_pkg::PH_DX: begin
					held_n  = in_byte;
					phase_n = bmprle_pkg::PH_DY;
				end
				bmprle_pkg::PH_DY: begin
					column_n   = col_clamped;
					file_row_n = row_add;
					if (row_add >= SUM_W'(eff_h)) begin
						finished_n = 1'b1;
					end
					phase_n = bmprle_pkg::PH_COUNT;
				end
				bmprle_pkg::PH_ABS: begin
					// One or two absolute pixels at their offset in the run.
					run_v   = 1'b1;
					run_col = SUM_W'(column_q) + SUM_W'(abs_off);
					run_len = abs_step;
					if (nibble_mode) begin
						run_even = nib_hi;
						run_odd  = nib_lo;
					end
					abs_left_n = (abs_left_q > abs_step) ? (abs_left_q - abs_step) : '0;
					if (abs_left_q <= abs_step) begin
						column_n = col_clamped;
						phase_n  = pad_q ? bmprle_pkg::PH_PAD : bmprle_pkg::PH_COUNT;
					end
				end
				bmprle_pkg::PH_PAD: begin
					pad_n   = 1'b0;
					phase_n = bmprle_pkg::PH_COUNT;
				end
				default: begin
					held_n  = in_byte;
					phase_n = bmprle_pkg::PH_VALUE;
				end
			endcase
		end

		// An escape or absolute run still open when the stream ends.
		run_open = !finished_n && ((phase_n == bmprle_pkg::PH_DX) ||
			(phase_n == bmprle_pkg::PH_DY) || (phase_n == bmprle_pkg::PH_ABS) ||
			(phase_n == bmprle_pkg::PH_PAD));

		// The final byte returns the stream state to its start.
		if (in_final) begin
			phase_n    = bmprle_pkg::PH_COUNT;
			held_n     = '0;
			column_n   = '0;
			file_row_n = '0;
			abs_left_n = '0;
			pad_n      = 1'b0;
			finished_n = 1'b0;
		end
	end

	// Command record for the result stage.
	always_comb begin
		cmd.run_v     = run_v;
		cmd.row       = bmprle_pkg::POS_W'(file_row_q);
		cmd.col       = bmprle_pkg::POS_W'(run_col);
		cmd.len       = run_len;
		cmd.even_idx  = run_even;
		cmd.odd_idx   = run_odd;
		cmd.stat_v    = in_final;
		cmd.stat_kind = run_open ? bmprle_pkg::KIND_TRUNC : bmprle_pkg::KIND_DONE;
	end

	assign push = in_accept && (run_v || in_final);

	// Parse state registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= bmprle_pkg::PH_COUNT;
			held_q     <= '0;
			column_q   <= '0;
			file_row_q <= '0;
			abs_left_q <= '0;
			pad_q      <= 1'b0;
			finished_q <= 1'b0;
		end else if (in_accept) begin
			phase_q    <= phase_n;
			held_q     <= held_n;
			column_q   <= column_n;
			file_row_q <= file_row_n;
			abs_left_q <= abs_left_n;
			pad_q      <= pad_n;
			finished_q <= finished_n;
		end
	end

`ifndef NO_ASSERTIONS
	// Once the bitmap has ended, the parser waits at the count phase.
	a_finished_idle: assert property (@(posedge clk) disable iff (!arst_n)
		finished_q |-> (phase_q == bmprle_pkg::PH_COUNT))
		else $error("finished stream left the count phase");

	// An absolute run in progress always has pixels left.
	a_abs_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == bmprle_pkg::PH_ABS) |-> (abs_left_q != '0))
		else $error("absolute phase with no pixels left");
`endif

endmodule

### src/bmprle_queue.sv
// ----------------------------------------------------------------------------
// BMP RLE command queue
// Short first-in first-out queue of parsed commands between the parser and
// the result stage.
// ----------------------------------------------------------------------------
module bmprle_queue #(
	parameter int DEPTH = bmprle_pkg::QUEUE_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  bmprle_pkg::cmd_t  push_cmd,
	input  logic              pop,
	output logic              full,
	output logic              head_valid,
	output bmprle_pkg::cmd_t  head_cmd
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	bmprle_pkg::cmd_t   entry_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = entry_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

`ifndef NO_ASSERTIONS
	// No item is pushed into a full queue or popped from an empty one.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!full || pop))
		else $error("command queue overflow");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("command queue underflow");
`endif

endmodule

### src/bmprle_back.sv
// ----------------------------------------------------------------------------
// BMP RLE result stage
// Clips queued run writes to the image, flips the row when needed and drives
// the registered result channel, one result item per cycle while m_tready is high.
// ----------------------------------------------------------------------------
module bmprle_back #(
	parameter int MAX_DIMENSION = bmprle_pkg::MAX_DIMENSION_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic [$clog2(MAX_DIMENSION + 1)-1:0]  eff_w,
	input  logic [$clog2(MAX_DIMENSION + 1)-1:0]  eff_h,
	input  logic                                  rows_top_down,
	input  logic                                  head_valid,
	input  bmprle_pkg::cmd_t                      head_cmd,
	output logic                                  pop,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [bmprle_pkg::M_TDATA_W-1:0]      m_tdata,
	output logic [bmprle_pkg::KIND_W-1:0]         m_tuser,
	output logic                                  m_tlast
);

	localparam int SUM_W = $clog2(MAX_DIMENSION + 256);
	localparam int PAD_W = bmprle_pkg::M_TDATA_W - 2 * bmprle_pkg::ROW_OUT_W
		- 3 * bmprle_pkg::LEN_W;

	logic                                 out_valid_q;
	logic [bmprle_pkg::M_TDATA_W-1:0]     out_data_q;
	bmprle_pkg::kind_t                    out_kind_q;
	logic                                 out_last_q;
	logic                                 run_sent_q;

	logic [SUM_W-1:0]                     row;
	logic [SUM_W-1:0]                     col;
	logic                                 row_ok;
	logic                                 col_ok;
	logic [SUM_W-1:0]                     room;
	logic [bmprle_pkg::LEN_W-1:0]         len_clip;
	logic [SUM_W-1:0]                     dest_row;
	logic [bmprle_pkg::POS_W-1:0]         dest_full;
	logic [bmprle_pkg::POS_W-1:0]         col_full;
	logic                                 run_pend;
	logic                                 load_ok;
	logic                                 load;
	logic [bmprle_pkg::M_TDATA_W-1:0]     load_data;
	bmprle_pkg::kind_t                    load_kind;
	logic                                 load_last;

	// Clipping of the head write against the image.
	assign row      = head_cmd.row[SUM_W-1:0];
	assign col      = head_cmd.col[SUM_W-1:0];
	assign row_ok   = row < SUM_W'(eff_h);
	assign col_ok   = col < SUM_W'(eff_w);
	assign room     = SUM_W'(eff_w) - col;
	assign len_clip = (SUM_W'(head_cmd.len) > room) ? room[bmprle_pkg::LEN_W-1:0]
		: head_cmd.len;
	assign dest_row = rows_top_down ? row : (SUM_W'(eff_h) - SUM_W'(1) - row);
	assign dest_full = bmprle_pkg::POS_W'(dest_row);
	assign col_full  = bmprle_pkg::POS_W'(col);

	assign run_pend = head_cmd.run_v && row_ok && col_ok && !run_sent_q;
	assign load_ok  = !out_valid_q || m_tready;

	// Choose the next result item: the run write first, then the status.
	always_comb begin
		pop       = 1'b0;
		load      = 1'b0;
		load_kind = bmprle_pkg::KIND_RUN;
		load_last = 1'b1;
		load_data = '0;
		if (head_valid) begin
			if (run_pend) begin
				if (load_ok) begin
					load      = 1'b1;
					load_last = !head_cmd.stat_v;
					pop       = !head_cmd.stat_v;
					load_data = {PAD_W'(0), head_cmd.odd_idx, head_cmd.even_idx, len_clip,
						col_full[bmprle_pkg::ROW_OUT_W-1:0],
						dest_full[bmprle_pkg::ROW_OUT_W-1:0]};
				end
			end else if (head_cmd.stat_v) begin
				if (load_ok) begin
					load      = 1'b1;
					load_kind = head_cmd.stat_kind;
					pop       = 1'b1;
				end
			end else begin
				// The write was clipped away entirely.
				pop = 1'b1;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			run_sent_q  <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (load_ok) begin
				out_valid_q <= 1'b0;
			end
			if (pop) begin
				run_sent_q <= 1'b0;
			end else if (load && run_pend) begin
				run_sent_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q <= load_data;
			out_kind_q <= load_kind;
			out_last_q <= load_last;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

`ifndef NO_ASSERTIONS
	// A status item is always the last item of its byte and carries no pixels.
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_kind_q != bmprle_pkg::KIND_RUN)) |->
		(out_last_q && (out_data_q == '0)))
		else $error("status item malformed");

	// A run write never has zero length.
	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && (out_kind_q == bmprle_pkg::KIND_RUN)) |->
		(out_data_q[2*bmprle_pkg::ROW_OUT_W +: bmprle_pkg::LEN_W] != '0))
		else $error("run write of zero length");
`endif

endmodule

### src/bmp_rle_pixel_decoder_core.sv
// ----------------------------------------------------------------------------
// BMP RLE pixel decoder core
// Decodes an RLE8 or RLE4 compressed pixel stream into clipped run writes
// and a final status item.
// ----------------------------------------------------------------------------
// The core takes one compressed byte per clock cycle while its queue has
// room and gives, for each byte, up to two result items: a clipped pixel
// run write (kind 0) and, on the byte marked tlast, a status item (kind 1
// finished, kind 2 truncated). The parser updates its state in the cycle a
// byte is accepted and places a command in a four-entry queue; the result
// stage drains that queue through a registered output, one result item per
// cycle while m_tready is high. The sustained rate is one byte per cycle
// while each byte gives at most one result item; a final byte that also
// ends a run gives two result items, which the queue absorbs. The consumer
// must clear its index store to zero before each stream. The user must write
// configuration only while no result item is pending; the core does not enforce it.
module bmp_rle_pixel_decoder_core #(
	parameter int MAX_DIMENSION = bmprle_pkg::MAX_DIMENSION_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// Input items.
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [bmprle_pkg::DATA_W-1:0]         s_tdata,  // [7:0] stream_byte
	input  logic                                  s_tlast,  // final_byte
	// Result items.
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// [12:0] dest_row, [25:13] start_column, [33:26] run_length,
	// [41:34] even_index, [49:42] odd_index, [55:50] zero
	output logic [bmprle_pkg::M_TDATA_W-1:0]      m_tdata,
	output logic [bmprle_pkg::KIND_W-1:0]         m_tuser,  // [1:0] kind
	output logic                                  m_tlast,  // last_result
	// Configuration writes.
	input  logic                                  cfg_we,
	input  logic [bmprle_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [bmprle_pkg::CFG_W-1:0]          cfg_data
);

	localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
	localparam int CMP_W = bmprle_pkg::CFG_W + 1;

	logic [bmprle_pkg::CFG_W-1:0]  image_width_q;
	logic [bmprle_pkg::CFG_W-1:0]  image_height_q;
	logic                          nibble_mode_q;
	logic                          rows_top_down_q;

	logic [DIM_W-1:0]              eff_w;
	logic [DIM_W-1:0]              eff_h;
	logic                          in_accept;
	logic                          push;
	bmprle_pkg::cmd_t              push_cmd;
	logic                          pop;
	logic                          q_full;
	logic                          head_valid;
	bmprle_pkg::cmd_t              head_cmd;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q   <= bmprle_pkg::CFG_W'(1);
			image_height_q  <= bmprle_pkg::CFG_W'(1);
			nibble_mode_q   <= 1'b0;
			rows_top_down_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (bmprle_pkg::reg_idx_t'(cfg_index))
				bmprle_pkg::REG_IMAGE_WIDTH:   image_width_q   <= cfg_data;
				bmprle_pkg::REG_IMAGE_HEIGHT:  image_height_q  <= cfg_data;
				bmprle_pkg::REG_NIBBLE_MODE:   nibble_mode_q   <= cfg_data[0];
				bmprle_pkg::REG_ROWS_TOP_DOWN: rows_top_down_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Sizes saturated at the largest supported dimension.
	assign eff_w = ({1'b0, image_width_q} > CMP_W'(MAX_DIMENSION))
		? DIM_W'(MAX_DIMENSION) : DIM_W'(image_width_q);
	assign eff_h = ({1'b0, image_height_q} > CMP_W'(MAX_DIMENSION))
		? DIM_W'(MAX_DIMENSION) : DIM_W'(image_height_q);

	assign s_tready  = !q_full;
	assign in_accept = s_tvalid && s_tready;

	// Parser.
	bmprle_front #(
		.MAX_DIMENSION (MAX_DIMENSION)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.eff_w       (eff_w),
		.eff_h       (eff_h),
		.nibble_mode (nibble_mode_q),
		.in_accept   (in_accept),
		.in_byte     (s_tdata),
		.in_final    (s_tlast),
		.push        (push),
		.cmd         (push_cmd)
	);

	// Command queue.
	bmprle_queue #(
		.DEPTH (bmprle_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head_cmd   (head_cmd)
	);

	// Result stage.
	bmprle_back #(
		.MAX_DIMENSION (MAX_DIMENSION)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.eff_w         (eff_w),
		.eff_h         (eff_h),
		.rows_top_down (rows_top_down_q),
		.head_valid    (head_valid),
		.head_cmd      (head_cmd),
		.pop           (pop),
		.m_tvalid      (m_tvalid),
		.m_tready      (m_tready),
		.m_tdata       (m_tdata),
		.m_tuser       (m_tuser),
		.m_tlast       (m_tlast)
	);

endmodule
